FILE: src/bdm_pkg.sv
// Shared types and constants for the balanced delimiter matcher.
package bdm_pkg;

  localparam int STACK_DEPTH_DEF = 32;
  localparam int MAX_DELIM_DEF   = 8;
  localparam int POS_WIDTH_DEF   = 16;

  localparam int BYTE_W       = 8;
  localparam int PAT_W        = 64;
  localparam int LEN_W        = 4;
  localparam int POS_FIELD_W  = 16;
  localparam int STATUS_W     = 2;
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_ADDR_W   = 5;
  localparam int OUT_USED_W   = STATUS_W + 2 * POS_FIELD_W;
  localparam int OUT_TDATA_W  = ((OUT_USED_W + 7) / 8) * 8;
  localparam int QUEUE_DEPTH  = 4;

  localparam logic [PAT_W-1:0] OPEN_PATTERN_RST  = 64'd123;
  localparam logic [PAT_W-1:0] CLOSE_PATTERN_RST = 64'd125;
  localparam logic [LEN_W-1:0] LENGTH_RST        = 4'd1;

  localparam logic [STATUS_W-1:0] STATUS_NONE     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FOUND    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

  typedef enum logic [1:0] {
    REG_OPEN_PATTERN,
    REG_OPEN_LENGTH,
    REG_CLOSE_PATTERN,
    REG_CLOSE_LENGTH
  } reg_index_t;

  typedef enum logic [1:0] {
    PH_WAIT,
    PH_OPEN,
    PH_FOUND,
    PH_OVER
  } phase_t;

  typedef struct packed {
    logic [PAT_W-1:0] open_pattern;
    logic [LEN_W-1:0] open_length;
    logic [PAT_W-1:0] close_pattern;
    logic [LEN_W-1:0] close_length;
  } cfg_t;

  typedef struct packed {
    logic [POS_FIELD_W-1:0] end_pos;
    logic [POS_FIELD_W-1:0] start_pos;
    logic [STATUS_W-1:0]    status;
  } result_t;

endpackage

FILE: src/bdm_regs.sv
// Configuration register file behind the APB-style port.
module bdm_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bdm_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [bdm_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [bdm_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready,
  output bdm_pkg::cfg_t                   cfg
);
  import bdm_pkg::*;

  reg_index_t index;
  logic       wr_en;

  assign pready = 1'b1;
  assign index  = reg_index_t'(paddr[CFG_ADDR_W-1:3]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.open_pattern  <= OPEN_PATTERN_RST;
      cfg.open_length   <= LENGTH_RST;
      cfg.close_pattern <= CLOSE_PATTERN_RST;
      cfg.close_length  <= LENGTH_RST;
    end else if (wr_en) begin
      case (index)
        REG_OPEN_PATTERN:  cfg.open_pattern  <= pwdata;
        REG_OPEN_LENGTH:   cfg.open_length   <= pwdata[LEN_W-1:0];
        REG_CLOSE_PATTERN: cfg.close_pattern <= pwdata;
        REG_CLOSE_LENGTH:  cfg.close_length  <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (index)
      REG_OPEN_PATTERN:  prdata = cfg.open_pattern;
      REG_OPEN_LENGTH:   prdata = CFG_DATA_W'(cfg.open_length);
      REG_CLOSE_PATTERN: prdata = cfg.close_pattern;
      REG_CLOSE_LENGTH:  prdata = CFG_DATA_W'(cfg.close_length);
      default:           prdata = '0;
    endcase
  end

endmodule

FILE: src/bdm_front.sv
// Front end: byte window, position count and delimiter classification.
module bdm_front #(
  parameter int MAX_DELIM = bdm_pkg::MAX_DELIM_DEF,
  parameter int POS_WIDTH = bdm_pkg::POS_WIDTH_DEF,
  parameter int ENTRY_W   = 2 * bdm_pkg::MAX_DELIM_DEF + bdm_pkg::POS_WIDTH_DEF + 5
) (
  input  logic                        clk,
  input  logic                        rst,
  input  bdm_pkg::cfg_t               cfg,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [bdm_pkg::BYTE_W-1:0]  in_byte,
  input  logic                        in_last,
  output logic                        push,
  output logic [ENTRY_W-1:0]          entry
);
  import bdm_pkg::*;

  localparam int PW1 = POS_WIDTH + 1;
  localparam int LAG = MAX_DELIM - 1;
  localparam int IW  = (MAX_DELIM > 1) ? $clog2(MAX_DELIM) : 1;

  logic [BYTE_W-1:0]    win     [MAX_DELIM];
  logic [BYTE_W-1:0]    shifted [MAX_DELIM];
  logic [PW1-1:0]       pos;
  logic [LEN_W-1:0]     open_n;
  logic [LEN_W-1:0]     close_n;
  logic [MAX_DELIM-1:0] open_hit;
  logic [MAX_DELIM-1:0] close_hit;
  logic [IW-1:0]        start_idx;
  logic                 accept;
  logic                 judged_now;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] n;
    n = len;
    if (len == '0)
      n = LEN_W'(1);
    else if (len > LEN_W'(MAX_DELIM))
      n = LEN_W'(MAX_DELIM);
    return n;
  endfunction

  assign open_n  = clamp_len(cfg.open_length);
  assign close_n = clamp_len(cfg.close_length);

  always_comb begin
    for (int i = 0; i < MAX_DELIM - 1; i++)
      shifted[i] = win[i + 1];
    shifted[MAX_DELIM-1] = in_byte;
  end

  // Hit at start i: the delimiter fits the window and every byte compares equal.
  always_comb begin
    for (int i = 0; i < MAX_DELIM; i++) begin
      open_hit[i]  = (i + int'(open_n)) <= MAX_DELIM;
      close_hit[i] = (i + int'(close_n)) <= MAX_DELIM;
      for (int k = 0; k < MAX_DELIM; k++) begin
        if (i + k < MAX_DELIM) begin
          if (k < int'(open_n) && shifted[i+k] != cfg.open_pattern[8*k +: 8])
            open_hit[i] = 1'b0;
          if (k < int'(close_n) && shifted[i+k] != cfg.close_pattern[8*k +: 8])
            close_hit[i] = 1'b0;
        end
      end
    end
  end

  assign accept     = in_valid && in_ready;
  assign judged_now = pos >= PW1'(LAG);
  assign start_idx  = judged_now ? '0 : IW'(PW1'(LAG) - pos);
  assign push       = accept && (in_last || judged_now);
  assign entry      = {start_idx, in_last, pos, close_hit, open_hit};

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (accept) begin
      if (in_last)
        pos <= '0;
      else if (pos != '1)
        pos <= pos + PW1'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept)
      win <= shifted;
  end

endmodule

FILE: src/bdm_queue.sv
// Short queue of classified bytes between front and back end.
module bdm_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             ready,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] pop_data
);
  import bdm_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign ready    = count != CNT_W'(QUEUE_DEPTH);
  assign valid    = count != '0;
  assign pop_data = slots[rd_ptr];
  assign do_push  = push && ready;
  assign do_pop   = pop && valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push)
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (do_pop)
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      if (do_push && !do_pop)
        count <= count + CNT_W'(1);
      else if (do_pop && !do_push)
        count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push)
      slots[wr_ptr] <= push_data;
  end

endmodule

FILE: src/bdm_back.sv
// Back end: opener stack, leftmost pair tracking and result register.
module bdm_back #(
  parameter int STACK_DEPTH = bdm_pkg::STACK_DEPTH_DEF,
  parameter int MAX_DELIM   = bdm_pkg::MAX_DELIM_DEF,
  parameter int POS_WIDTH   = bdm_pkg::POS_WIDTH_DEF,
  parameter int ENTRY_W     = 2 * bdm_pkg::MAX_DELIM_DEF + bdm_pkg::POS_WIDTH_DEF + 5
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  logic [ENTRY_W-1:0] q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output bdm_pkg::result_t   out_data
);
  import bdm_pkg::*;

  localparam int PW1 = POS_WIDTH + 1;
  localparam int LAG = MAX_DELIM - 1;
  localparam int IW  = (MAX_DELIM > 1) ? $clog2(MAX_DELIM) : 1;
  localparam int LVW = $clog2(STACK_DEPTH + 1);
  localparam int AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // Top two stack entries live in registers, deeper ones in memory.
  logic [POS_WIDTH-1:0] stack_mem [STACK_DEPTH];
  logic [POS_WIDTH-1:0] rd_q;

  phase_t               phase, phase_j;
  logic [LVW-1:0]       level, level_j, level_next, level_m3, level_m2;
  logic [POS_WIDTH-1:0] top, top_j, sec, sec_j;
  logic [POS_WIDTH-1:0] lms, lms_j, lme, lme_j, popped;
  logic                 lmv, lmv_j;
  logic                 mem_we, wen;
  logic [AW-1:0]        raddr, waddr;

  logic                 active;
  logic [IW-1:0]        idx_reg, idx, end_idx;

  logic [MAX_DELIM-1:0] e_open, e_close;
  logic [PW1-1:0]       e_pos, s;
  logic                 e_last;
  logic [IW-1:0]        e_start;
  logic [POS_WIDTH-1:0] s_pos;

  logic s_over, full, hunting, push_try, push_fail, do_push, close_try;
  logic done_entry, out_free, step, finish;
  result_t result;
  logic [POS_FIELD_W+POS_WIDTH-1:0] start_ext, end_ext;

  assign e_open  = q_data[MAX_DELIM-1:0];
  assign e_close = q_data[2*MAX_DELIM-1:MAX_DELIM];
  assign e_pos   = q_data[2*MAX_DELIM +: PW1];
  assign e_last  = q_data[2*MAX_DELIM+PW1];
  assign e_start = q_data[2*MAX_DELIM+PW1+1 +: IW];

  // A final byte walks all pending starts, one per cycle; the last start waits until the output is free.
  assign idx        = active ? idx_reg : e_start;
  assign end_idx    = e_last ? IW'(MAX_DELIM - 1) : '0;
  assign done_entry = idx == end_idx;
  assign out_free   = !out_valid || out_ready;
  assign step       = q_valid && (!(done_entry && e_last) || out_free);
  assign finish     = step && done_entry && e_last;
  assign q_pop      = step && done_entry;

  assign s      = e_pos + PW1'(idx) - PW1'(LAG);
  assign s_pos  = s[POS_WIDTH-1:0];
  assign s_over = s[POS_WIDTH];
  assign full   = level == LVW'(STACK_DEPTH);

  assign hunting   = (phase == PH_WAIT) || (phase == PH_OPEN);
  assign push_try  = hunting && e_open[idx];
  assign push_fail = push_try && (s_over || full);
  assign do_push   = push_try && !push_fail;
  assign close_try = !push_fail && (do_push || phase == PH_OPEN) && e_close[idx];

  // Next state of the search for one delimiter start.
  always_comb begin
    phase_j = phase;
    level_j = level;
    top_j   = top;
    sec_j   = sec;
    lms_j   = lms;
    lme_j   = lme;
    lmv_j   = lmv;
    mem_we  = 1'b0;
    popped  = do_push ? s_pos : top;
    if (push_fail) begin
      phase_j = PH_OVER;
    end else if (close_try && s_over) begin
      phase_j = PH_OVER;
    end else if (close_try && (level == '0 || (level == LVW'(1) && !do_push))) begin
      lms_j   = popped;
      lme_j   = s_pos;
      lmv_j   = 1'b1;
      level_j = '0;
      phase_j = PH_FOUND;
    end else if (close_try) begin
      if (!lmv || popped < lms) begin
        lms_j = popped;
        lme_j = s_pos;
        lmv_j = 1'b1;
      end
      // An opener and closer at one start cancel out on the stack.
      if (!do_push) begin
        level_j = level - LVW'(1);
        top_j   = sec;
        sec_j   = rd_q;
      end
    end else if (do_push) begin
      phase_j = PH_OPEN;
      level_j = level + LVW'(1);
      top_j   = s_pos;
      sec_j   = top;
      mem_we  = level >= LVW'(2);
    end
  end

  // Result of the string from the state after its last judge step.
  always_comb begin
    start_ext = {{POS_FIELD_W{1'b0}}, lms_j};
    end_ext   = {{POS_FIELD_W{1'b0}}, lme_j};
    result    = '0;
    if (phase_j == PH_OVER) begin
      result.status = STATUS_OVERFLOW;
    end else if ((phase_j == PH_FOUND || phase_j == PH_OPEN) && lmv_j) begin
      result.status    = STATUS_FOUND;
      result.start_pos = start_ext[POS_FIELD_W-1:0];
      result.end_pos   = end_ext[POS_FIELD_W-1:0];
    end else begin
      result.status = STATUS_NONE;
    end
  end

  assign level_next = finish ? '0 : (step ? level_j : level);
  assign level_m3   = level_next - LVW'(3);
  assign level_m2   = level - LVW'(2);
  assign raddr      = level_m3[AW-1:0];
  assign waddr      = level_m2[AW-1:0];
  assign wen        = step && mem_we;

  always_ff @(posedge clk) begin
    if (wen)
      stack_mem[waddr] <= sec;
    rd_q <= (wen && waddr == raddr) ? sec : stack_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_WAIT;
      level     <= '0;
      lms       <= '0;
      lme       <= '0;
      lmv       <= 1'b0;
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (step) begin
        active <= !done_entry;
        if (finish) begin
          phase <= PH_WAIT;
          level <= '0;
          lms   <= '0;
          lme   <= '0;
          lmv   <= 1'b0;
        end else begin
          phase <= phase_j;
          level <= level_j;
          lms   <= lms_j;
          lme   <= lme_j;
          lmv   <= lmv_j;
        end
      end
      out_valid <= finish || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      top     <= top_j;
      sec     <= sec_j;
      idx_reg <= idx + IW'(1);
    end
    if (finish)
      out_data <= result;
  end

  assert property (@(posedge clk) disable iff (rst) level <= LVW'(STACK_DEPTH))
    else $error("stack level beyond depth");
  assert property (@(posedge clk) disable iff (rst) phase == PH_FOUND |-> lmv)
    else $error("found phase without a recorded pair");
  assert property (@(posedge clk) disable iff (rst) phase == PH_WAIT |-> level == '0)
    else $error("stack not empty before first opener");
  assert property (@(posedge clk) disable iff (rst) phase == PH_OPEN |-> level != '0)
    else $error("open phase with empty stack");
  assert property (@(posedge clk) disable iff (rst) finish |=> out_valid)
    else $error("finished string produced no result");

endmodule

FILE: src/balanced_delimiter_match.sv
// Throughput: one subject byte per cycle while the queue has room; the last byte of a string
//   holds the back end while it judges each delimiter start still pending there.
// Result: with the queue empty and the output free, the result becomes valid once the back
//   end has judged every start pending at the last byte, one judge step per cycle.
// Reset: synchronous, active high; registers return to their defaults, search state
//   clears at once, and the opener stack memory is not cleared.
module balanced_delimiter_match #(
  parameter int STACK_DEPTH = bdm_pkg::STACK_DEPTH_DEF,
  parameter int MAX_DELIM   = bdm_pkg::MAX_DELIM_DEF,
  parameter int POS_WIDTH   = bdm_pkg::POS_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bdm_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [bdm_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [bdm_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [bdm_pkg::BYTE_W-1:0]       s_tdata,   // [7:0] subject_byte
  input  logic                             s_tlast,   // last_byte
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [1:0] match_status, [17:2] start_position, [33:18] end_position, rest zero
  output logic [bdm_pkg::OUT_TDATA_W-1:0]  m_tdata
);
  import bdm_pkg::*;

  localparam int IW      = (MAX_DELIM > 1) ? $clog2(MAX_DELIM) : 1;
  localparam int ENTRY_W = 2 * MAX_DELIM + POS_WIDTH + 2 + IW;

  cfg_t               cfg;
  logic               q_push, q_valid, q_pop;
  logic [ENTRY_W-1:0] q_in, q_out;
  result_t            res;

  bdm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bdm_front #(
    .MAX_DELIM (MAX_DELIM),
    .POS_WIDTH (POS_WIDTH),
    .ENTRY_W   (ENTRY_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_byte  (s_tdata),
    .in_last  (s_tlast),
    .push     (q_push),
    .entry    (q_in)
  );

  bdm_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .ready     (s_tready),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_out)
  );

  bdm_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .MAX_DELIM   (MAX_DELIM),
    .POS_WIDTH   (POS_WIDTH),
    .ENTRY_W     (ENTRY_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (res)
  );

  assign m_tdata = {{(OUT_TDATA_W - OUT_USED_W){1'b0}}, res.end_pos, res.start_pos, res.status};

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench for balanced_delimiter_match: streams subject strings, predicts every match result.
module tb_top;
  import bdm_pkg::*;

  localparam int          LAG           = MAX_DELIM_DEF - 1;
  localparam int unsigned POS_LIMIT     = (1 << POS_WIDTH_DEF) - 1;
  localparam int unsigned COUNT_LIMIT   = (1 << (POS_WIDTH_DEF + 1)) - 1;
  localparam int          IDLE_LIMIT    = 4000;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          SETTLE_CYCLES = MAX_DELIM_DEF + 4;
  localparam logic [7:0]  OPEN_CH       = 8'h7B;
  localparam logic [7:0]  CLOSE_CH      = 8'h7D;
  localparam logic [7:0]  FILL_CH       = 8'h61;

  logic                   clk     = 1'b0;
  logic                   rst     = 1'b1;
  logic                   psel    = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0]  paddr   = '0;
  logic [CFG_DATA_W-1:0]  pwdata  = '0;
  logic [CFG_DATA_W-1:0]  prdata;
  logic                   pready;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [BYTE_W-1:0]      s_tdata  = '0;    // [7:0] subject_byte
  logic                   s_tlast  = 1'b0;  // last_byte
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // [1:0] match_status, [17:2] start_position, [33:18] end_position, rest zero
  logic [OUT_TDATA_W-1:0] m_tdata;

  balanced_delimiter_match DUT (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // Matcher copy: delimiter settings and per-string search state.
  logic [PAT_W-1:0] cfg_open_pat, cfg_close_pat;
  logic [LEN_W-1:0] cfg_open_len, cfg_close_len;
  logic [7:0]       window [MAX_DELIM_DEF];
  int unsigned      byte_count;
  int unsigned      open_starts [STACK_DEPTH_DEF];
  int unsigned      open_depth;
  int unsigned      best_start, best_end;
  bit               best_valid;
  bit               scan_overflow;
  phase_t           scan_phase;

  result_t          pending_matches [$];
  logic [7:0]       subject_bytes [$];
  int               mismatch_count  = 0;
  int unsigned      sender_gap_pct  = 0;
  int unsigned      stall_pct       = 0;
  bit               hold_on         = 1'b0;
  int               hold_count      = 0;
  int               idle_cycles     = 0;

  function automatic int unsigned delim_span(logic [LEN_W-1:0] len);
    if (len == 0) return 1;
    if (len > MAX_DELIM_DEF) return MAX_DELIM_DEF;
    return int'(len);
  endfunction

  function automatic bit delim_hits(logic [PAT_W-1:0] pat, logic [LEN_W-1:0] len,
                                    int unsigned at);
    int unsigned n;
    n = delim_span(len);
    if (at + n > MAX_DELIM_DEF) return 1'b0;
    for (int k = 0; k < n; k++)
      if (window[at + k] != pat[8*k +: 8]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void clear_search();
    for (int i = 0; i < MAX_DELIM_DEF; i++) window[i] = 8'h00;
    byte_count    = 0;
    open_depth    = 0;
    best_start    = 0;
    best_end      = 0;
    best_valid    = 1'b0;
    scan_overflow = 1'b0;
    scan_phase    = PH_WAIT;
  endfunction

  // Opener is handled before a closer at the same start.
  function automatic void judge_start(int unsigned at, int unsigned s);
    if (scan_phase == PH_WAIT || scan_phase == PH_OPEN) begin
      if (delim_hits(cfg_open_pat, cfg_open_len, at)) begin
        if (s > POS_LIMIT || open_depth >= STACK_DEPTH_DEF) begin
          scan_overflow = 1'b1;
          scan_phase    = PH_OVER;
          return;
        end
        open_starts[open_depth] = s;
        open_depth++;
        scan_phase = PH_OPEN;
      end
    end
    if (scan_phase == PH_OPEN && delim_hits(cfg_close_pat, cfg_close_len, at)) begin
      if (s > POS_LIMIT) begin
        scan_overflow = 1'b1;
        scan_phase    = PH_OVER;
        return;
      end
      if (open_depth <= 1) begin
        best_start = open_starts[0];
        best_end   = s;
        best_valid = 1'b1;
        open_depth = 0;
        scan_phase = PH_FOUND;
      end else begin
        open_depth--;
        if (!best_valid || open_starts[open_depth] < best_start) begin
          best_start = open_starts[open_depth];
          best_end   = s;
          best_valid = 1'b1;
        end
      end
    end
  endfunction

  // Returns 1 when the byte ends a string, with the match result in outcome.
  function automatic bit advance_matcher(logic [7:0] b, bit last, output result_t outcome);
    int unsigned p, first;
    outcome = '0;
    p = byte_count;
    for (int i = 0; i < MAX_DELIM_DEF - 1; i++) window[i] = window[i + 1];
    window[MAX_DELIM_DEF - 1] = b;
    if (byte_count < COUNT_LIMIT) byte_count++;
    if (p >= LAG) judge_start(0, p - LAG);
    if (!last) return 1'b0;
    // Judge every start still pending; delimiters must end inside the string.
    first = (p >= LAG) ? 1 : LAG - p;
    for (int unsigned idx = first; idx < MAX_DELIM_DEF; idx++)
      judge_start(idx, p + idx - LAG);
    if (scan_phase == PH_OVER || scan_overflow) begin
      outcome.status = STATUS_OVERFLOW;
    end else if ((scan_phase == PH_FOUND || scan_phase == PH_OPEN) && best_valid) begin
      outcome.status    = STATUS_FOUND;
      outcome.start_pos = POS_FIELD_W'(best_start);
      outcome.end_pos   = POS_FIELD_W'(best_end);
    end else begin
      outcome.status = STATUS_NONE;
    end
    clear_search();
    return 1'b1;
  endfunction

  // Append one byte to the subject being built.
  function automatic void queue_byte(logic [7:0] b);
    subject_bytes.insert(subject_bytes.size(), b);
  endfunction

  task automatic send_byte(logic [7:0] b, bit last);
    result_t outcome;
    while ($urandom_range(99) < sender_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    if (advance_matcher(b, last, outcome))
      pending_matches.insert(pending_matches.size(), outcome);
  endtask

  task automatic send_text(string t);
    for (int i = 0; i < t.len(); i++) send_byte(t[i], i == t.len() - 1);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_OPEN_PATTERN:  cfg_open_pat  = value;
      REG_OPEN_LENGTH:   cfg_open_len  = value[LEN_W-1:0];
      REG_CLOSE_PATTERN: cfg_close_pat = value;
      REG_CLOSE_LENGTH:  cfg_close_len = value[LEN_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Length writes carry random upper bits, which the block must drop.
  task automatic set_delimiters(logic [PAT_W-1:0] open_pat, logic [LEN_W-1:0] open_len,
                                logic [PAT_W-1:0] close_pat, logic [LEN_W-1:0] close_len);
    settle();
    write_reg(REG_OPEN_PATTERN, open_pat);
    write_reg(REG_OPEN_LENGTH, ({$urandom, $urandom} & ~64'hF) | 64'(open_len));
    write_reg(REG_CLOSE_PATTERN, close_pat);
    write_reg(REG_CLOSE_LENGTH, ({$urandom, $urandom} & ~64'hF) | 64'(close_len));
  endtask

  function automatic void add_delimiter(logic [PAT_W-1:0] pat, logic [LEN_W-1:0] len);
    int unsigned n;
    n = delim_span(len);
    // Cut a delimiter short now and then.
    if (n > 1 && $urandom_range(9) == 0) n--;
    for (int k = 0; k < n; k++) queue_byte(pat[8*k +: 8]);
  endfunction

  // Reset settings: single-byte braces.
  task automatic test_basic_pairs();
    send_text("{}");
    send_byte(8'hFF, 1'b0);
    send_byte(CLOSE_CH, 1'b0);
    send_byte(OPEN_CH, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(CLOSE_CH, 1'b1);
    send_text("{{}");
    send_text("{{");
  endtask

  task automatic test_stack_full();
    repeat (STACK_DEPTH_DEF + 1) send_byte(OPEN_CH, 1'b0);
    send_byte(CLOSE_CH, 1'b1);
  endtask

  task automatic test_equal_delimiters();
    set_delimiters(64'h7C, 4'd1, 64'h7C, 4'd1);
    send_text("a||");
  endtask

  // Length 0 acts as one byte, 15 as the widest delimiter.
  task automatic test_length_clamp();
    set_delimiters({$urandom, 24'($urandom), OPEN_CH}, 4'd0, {8{CLOSE_CH}}, 4'd15);
    send_byte(OPEN_CH, 1'b0);
    repeat (7) send_byte(CLOSE_CH, 1'b0);
    send_byte(CLOSE_CH, 1'b1);
  endtask

  // Pair ending at the top position, closer past it, opener past it.
  task automatic test_position_limit();
    set_delimiters(64'h7B, 4'd1, 64'h7D, 4'd1);
    sender_gap_pct = 0;
    stall_pct     <= 0;
    for (int n = 0; n < 3; n++) begin
      repeat (POS_LIMIT - 1 + n) send_byte(FILL_CH, 1'b0);
      send_byte(OPEN_CH, n == 2);
      if (n < 2) send_byte(CLOSE_CH, 1'b1);
    end
  endtask

  task automatic test_random_strings();
    int unsigned      gap_set [4]   = '{0, 66, 0, 35};
    int unsigned      stall_set [4] = '{0, 0, 66, 35};
    logic [7:0]       alphabet [4];
    logic [PAT_W-1:0] open_pat, close_pat;
    logic [LEN_W-1:0] open_len, close_len;
    int               sent, strings, r;
    for (int i = 0; i < 8; i++) begin
      foreach (alphabet[a]) alphabet[a] = 8'($urandom_range(255));
      if (i == 0) begin
        alphabet[0] = 8'h00;
        alphabet[1] = 8'hFF;
      end
      case (i)
        0: begin open_len = 4'd1; close_len = 4'd1; end
        1: begin open_len = 4'd8; close_len = 4'd8; end
        2: begin open_len = 4'd0; close_len = 4'd15; end
        3: begin open_len = 4'd9; close_len = 4'd2; end
        default: begin
          open_len  = LEN_W'($urandom_range(1, 8));
          close_len = LEN_W'($urandom_range(1, 8));
        end
      endcase
      open_pat  = {$urandom, $urandom};
      close_pat = {$urandom, $urandom};
      for (int k = 0; k < delim_span(open_len); k++)
        open_pat[8*k +: 8] = alphabet[$urandom_range(3)];
      for (int k = 0; k < delim_span(close_len); k++)
        close_pat[8*k +: 8] = alphabet[$urandom_range(3)];
      if (i == 5) begin
        close_pat = open_pat;
        close_len = open_len;
      end
      set_delimiters(open_pat, open_len, close_pat, close_len);
      sender_gap_pct = gap_set[i % 4];
      stall_pct     <= stall_set[i % 4];
      sent    = 0;
      strings = 0;
      while (sent < 50 || strings < 5) begin
        subject_bytes.delete();
        if ($urandom_range(99) < 15) begin
          repeat ($urandom_range(1, 10)) queue_byte(8'($urandom_range(255)));
        end else begin
          repeat ($urandom_range(1, 5)) begin
            r = $urandom_range(99);
            if (r < 40)
              add_delimiter(cfg_open_pat, cfg_open_len);
            else if (r < 75)
              add_delimiter(cfg_close_pat, cfg_close_len);
            else if (r < 88)
              queue_byte(alphabet[$urandom_range(3)]);
            else
              queue_byte(8'($urandom_range(255)));
          end
        end
        foreach (subject_bytes[j]) send_byte(subject_bytes[j], j == subject_bytes.size() - 1);
        sent += subject_bytes.size();
        strings++;
      end
    end
  endtask

  // Hold the output off while short strings keep coming, so the input stalls.
  task automatic test_backpressure();
    set_delimiters(64'h7B, 4'd1, 64'h7D, 4'd1);
    sender_gap_pct = 0;
    stall_pct     <= 0;
    hold_on       <= 1'b1;
    repeat (60) send_text("{}");
    hold_on       <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (hold_on && hold_count < HOLD_CYCLES) begin
      m_tready   <= 1'b0;
      hold_count <= hold_count + 1;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
      if (!hold_on) hold_count <= 0;
    end
  end

  always @(posedge clk) begin : check_results
    result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[OUT_USED_W-1:0];
      if (pending_matches.size() == 0) begin
        $display("%0t: unexpected result, expected none, got status %0d start %0d end %0d",
                 $time, got.status, got.start_pos, got.end_pos);
        mismatch_count++;
      end else begin
        want = pending_matches.pop_front();
        if (got.status !== want.status) begin
          $display("%0t: match_status expected %0d got %0d", $time, want.status, got.status);
          mismatch_count++;
        end
        if (got.start_pos !== want.start_pos) begin
          $display("%0t: start_position expected %0d got %0d",
                   $time, want.start_pos, got.start_pos);
          mismatch_count++;
        end
        if (got.end_pos !== want.end_pos) begin
          $display("%0t: end_position expected %0d got %0d", $time, want.end_pos, got.end_pos);
          mismatch_count++;
        end
        if (m_tdata[OUT_TDATA_W-1:OUT_USED_W] !== '0) begin
          $display("%0t: tdata padding expected 0 got %h",
                   $time, m_tdata[OUT_TDATA_W-1:OUT_USED_W]);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || psel || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("FAIL balanced_delimiter_match");
      $finish;
    end
  end

  initial begin
    cfg_open_pat  = OPEN_PATTERN_RST;
    cfg_open_len  = LENGTH_RST;
    cfg_close_pat = CLOSE_PATTERN_RST;
    cfg_close_len = LENGTH_RST;
    clear_search();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_basic_pairs();
    test_stack_full();
    test_equal_delimiters();
    test_length_clamp();
    test_position_limit();
    test_random_strings();
    test_backpressure();
    settle();
    repeat (2 * MAX_DELIM_DEF) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS balanced_delimiter_match");
    end else begin
      $display("FAIL balanced_delimiter_match");
    end
    $finish;
  end

endmodule
